>>> sv/bthal_pkg.sv
// Shared types and constants for the boundary-tag heap allocator.
`timescale 1ns / 1ps

package bthal_pkg;

   // Arena size the design is built for, in bytes
   localparam int unsigned HEAP_BYTES_DEF = 16384;

   // Header word width and header size in bytes
   localparam int unsigned HDR_W     = 15;
   localparam int unsigned HDR_BYTES = 4;

   // Arena length limits: any 15-bit length rounds up to at most 32768
   localparam int unsigned MIN_LEN   = 64;
   localparam int unsigned LEN_CAP   = 32768;
   localparam logic [14:0] RESET_LEN = 15'd16384;

   // Request codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_COMPACT = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   // Control register indexes
   typedef logic csr_index_type;
   localparam csr_index_type CSR_HEAP_BASE = 1'b0;
   localparam csr_index_type CSR_HEAP_LEN  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [14:0] size_bytes;
      logic [31:0] addr;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [31:0] block_addr;
      logic [14:0] block_bytes;
   } rsp_payload_type;

endpackage

>>> sv/bthal_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module bthal_ram #(
   parameter int unsigned WIDTH = 15,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: write, or read into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator: first fit with lazy coalescing, one header RAM.
`timescale 1ns / 1ps

// Takes one transaction at a time; req_ready is high only while the sequencer is idle.
// Every header access goes through the single port of the header RAM, and that port
// sets the timing. An allocate first tries the current free block; a release checks
// the address and goes straight to the response when it is rejected, as does a no-op or
// zero-size allocate. When the free block is missing or too small, the allocate walks the
// arena one header after another, with merged runs written back during the walk, and
// S_WALK_END closes the walk; headers lie at least 4 bytes apart. Compact walks the
// whole arena unless it meets a broken header. After reset the header RAM is cleared,
// one word a cycle, then the arena is built: the free block header, then the
// terminator; a write of the length register rebuilds it the same way. Configuration
// writes are taken only while idle. A finished response waits in an output register
// while the next transaction is accepted.
module boundary_tag_heap_allocator #(
   parameter int unsigned HEAP_BYTES = bthal_pkg::HEAP_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bthal_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bthal_pkg::rsp_payload_type rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  bthal_pkg::csr_index_type   csr_index,
   input  logic [31:0]                csr_wdata
);

   import bthal_pkg::*;

   // Arena geometry
   localparam int unsigned TOP_RAW = HEAP_BYTES & ~32'd3;
   localparam int unsigned TOP     = (TOP_RAW > LEN_CAP) ? LEN_CAP : TOP_RAW;
   localparam int unsigned OW      = $clog2(TOP);
   localparam int unsigned AW      = OW - 2;
   localparam int unsigned DEPTH   = TOP / 4;

   typedef enum logic [14:0] {
      S_CLEAR     = 15'b000000000000001,
      S_INIT_HEAD = 15'b000000000000010,
      S_INIT_TERM = 15'b000000000000100,
      S_IDLE      = 15'b000000000001000,
      S_FAST_RD   = 15'b000000000010000,
      S_FAST_CHK  = 15'b000000000100000,
      S_WALK_RD   = 15'b000000001000000,
      S_WALK_CHK  = 15'b000000010000000,
      S_WALK_END  = 15'b000000100000000,
      S_SPLIT     = 15'b000001000000000,
      S_MARK      = 15'b000010000000000,
      S_REL_CHK   = 15'b000100000000000,
      S_REL_RD    = 15'b001000000000000,
      S_REL_WR    = 15'b010000000000000,
      S_RESP      = 15'b100000000000000
   } state_type;

   // Terminator offset for a written arena length: round up, then saturate
   function automatic logic [OW-1:0] term_of(input logic [14:0] v);
      logic [15:0] len;
      len = (16'(v) + 16'd3) & ~16'd3;
      if (len < 16'(MIN_LEN)) len = 16'(MIN_LEN);
      if (len > 16'(TOP)) len = 16'(TOP);
      return OW'(len - 16'(HDR_BYTES));
   endfunction

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [OW-1:0]   term_ff, term_in;
   logic [31:0]     base_ff, base_in;
   logic [OW-1:0]   free_off_ff, free_off_in;
   logic            free_valid_ff, free_valid_in;
   logic            cmp_ff, cmp_in;
   logic [15:0]     size_ff, size_in;
   logic [31:0]     addr_ff, addr_in;
   logic [OW-1:0]   cur_p_ff, cur_p_in;
   logic [HDR_W-1:0] fsz_ff, fsz_in;
   logic [OW-1:0]   wp_ff, wp_in;
   logic [OW-1:0]   best_ff, best_in;
   logic [OW-1:0]   bsize_ff, bsize_in;
   rsp_payload_type res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [HDR_W-1:0] ram_wdata;
   logic [HDR_W-1:0] ram_rdata;

   bthal_ram #(
      .WIDTH(HDR_W),
      .DEPTH(DEPTH)
   ) u_hdr_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Handshakes
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Walk and carve helpers
   logic [HDR_W-1:0] hdr_sz;
   logic [OW-1:0]    walk_room;
   logic             hdr_broken;
   logic             run_hit;
   logic             split;
   logic [OW-1:0]    split_off;
   logic [31:0]      rel_off;
   logic             rel_ok;
   logic [OW-1:0]    fast_room;
   logic             fast_ok;

   always_comb begin
      hdr_sz     = {ram_rdata[HDR_W-1:2], 2'b00};
      walk_room  = term_ff - wp_ff;
      hdr_broken = (hdr_sz == '0) || (16'(hdr_sz) > 16'(walk_room));
      run_hit    = !cmp_ff && (16'(bsize_ff) >= size_ff);
      split      = 17'(fsz_ff) >= (17'(size_ff) + 17'(HDR_BYTES));
      split_off  = cur_p_ff + OW'(size_ff);
      rel_off    = addr_ff - base_ff - 32'(HDR_BYTES);
      rel_ok     = (addr_ff != '0) && (rel_off[1:0] == 2'b00) && (rel_off < 32'(term_ff));
      fast_room  = term_ff - free_off_ff;
      fast_ok    = free_valid_ff && (free_off_ff < term_ff) &&
                   (size_ff <= 16'(ram_rdata)) && (16'(ram_rdata) <= 16'(fast_room));
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      term_in       = term_ff;
      base_in       = base_ff;
      free_off_in   = free_off_ff;
      free_valid_in = free_valid_ff;
      cmp_in        = cmp_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      cur_p_in      = cur_p_ff;
      fsz_in        = fsz_ff;
      wp_in         = wp_ff;
      best_in       = best_ff;
      bsize_in      = bsize_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_addr      = '0;
      ram_wdata     = '0;

      // Output register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Zero the header RAM after reset
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_INIT_HEAD;
            end
         end
         // Build the arena: one free block, then the terminator
         S_INIT_HEAD: begin
            ram_we    = 1'b1;
            ram_wdata = HDR_W'(term_ff);
            state_in  = S_INIT_TERM;
         end
         S_INIT_TERM: begin
            ram_we        = 1'b1;
            ram_addr      = term_ff[OW-1:2];
            free_off_in   = '0;
            free_valid_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid) begin
               unique case (csr_index)
                  CSR_HEAP_BASE: base_in = csr_wdata;
                  CSR_HEAP_LEN: begin
                     term_in  = term_of(csr_wdata[14:0]);
                     state_in = S_INIT_HEAD;
                  end
                  default: ;
               endcase
            end else if (req_valid) begin
               res_in  = '0;
               cmp_in  = 1'b0;
               addr_in = req_data.addr;
               size_in = (16'(req_data.size_bytes) + 16'd7) & ~16'd3;
               wp_in    = '0;
               best_in  = '0;
               bsize_in = '0;
               unique case (req_data.req_type)
                  OP_ALLOC: begin
                     if (req_data.size_bytes == '0) begin
                        res_in.status = 1'b1;
                        state_in      = S_RESP;
                     end else begin
                        state_in = S_FAST_RD;
                     end
                  end
                  OP_RELEASE: state_in = S_REL_CHK;
                  OP_COMPACT: begin
                     cmp_in   = 1'b1;
                     state_in = S_WALK_RD;
                  end
                  OP_NOP:     state_in = S_RESP;
                  default:    state_in = S_RESP;
               endcase
            end
         end
         // Try the current free block
         S_FAST_RD: begin
            ram_addr = free_off_ff[OW-1:2];
            state_in = S_FAST_CHK;
         end
         S_FAST_CHK: begin
            fsz_in   = ram_rdata;
            cur_p_in = free_off_ff;
            state_in = fast_ok ? S_SPLIT : S_WALK_RD;
         end
         // First-fit walk with merging of free runs
         S_WALK_RD: begin
            ram_addr = wp_ff[OW-1:2];
            state_in = (wp_ff < term_ff) ? S_WALK_CHK : S_WALK_END;
         end
         S_WALK_CHK: begin
            if (hdr_broken) begin
               state_in = S_WALK_END;
            end else if (ram_rdata[0]) begin
               // Used block closes the current run
               if (bsize_ff != '0) begin
                  ram_we    = 1'b1;
                  ram_addr  = best_ff[OW-1:2];
                  ram_wdata = HDR_W'(bsize_ff);
               end
               if ((bsize_ff != '0) && run_hit) begin
                  cur_p_in      = best_ff;
                  fsz_in        = HDR_W'(bsize_ff);
                  free_off_in   = best_ff;
                  free_valid_in = 1'b1;
                  state_in      = S_SPLIT;
               end else begin
                  bsize_in = '0;
                  wp_in    = wp_ff + hdr_sz[OW-1:0];
                  best_in  = wp_ff + hdr_sz[OW-1:0];
                  state_in = S_WALK_RD;
               end
            end else begin
               bsize_in = bsize_ff + hdr_sz[OW-1:0];
               wp_in    = wp_ff + hdr_sz[OW-1:0];
               state_in = S_WALK_RD;
            end
         end
         S_WALK_END: begin
            if (bsize_ff != '0) begin
               ram_we    = 1'b1;
               ram_addr  = best_ff[OW-1:2];
               ram_wdata = HDR_W'(bsize_ff);
            end
            if ((bsize_ff != '0) && run_hit) begin
               cur_p_in      = best_ff;
               fsz_in        = HDR_W'(bsize_ff);
               free_off_in   = best_ff;
               free_valid_in = 1'b1;
               state_in      = S_SPLIT;
            end else begin
               // No fit: allocate fails, compact simply finishes
               free_valid_in = 1'b0;
               free_off_in   = '0;
               res_in.status = !cmp_ff;
               state_in      = S_RESP;
            end
         end
         // Carve: split off the rest when it can hold a header
         S_SPLIT: begin
            if (split) begin
               ram_we      = 1'b1;
               ram_addr    = split_off[OW-1:2];
               ram_wdata   = fsz_ff - HDR_W'(size_ff);
               free_off_in = split_off;
            end else begin
               size_in       = 16'(fsz_ff);
               free_valid_in = 1'b0;
               free_off_in   = '0;
            end
            state_in = S_MARK;
         end
         S_MARK: begin
            ram_we             = 1'b1;
            ram_addr           = cur_p_ff[OW-1:2];
            ram_wdata          = HDR_W'(size_ff) | HDR_W'(1);
            res_in.block_addr  = base_ff + 32'(cur_p_ff) + 32'(HDR_BYTES);
            res_in.block_bytes = HDR_W'(size_ff);
            state_in           = S_RESP;
         end
         // Release: clear the used mark of an aligned header inside the arena
         S_REL_CHK: begin
            cur_p_in = rel_off[OW-1:0];
            state_in = rel_ok ? S_REL_RD : S_RESP;
         end
         S_REL_RD: begin
            ram_addr = cur_p_ff[OW-1:2];
            state_in = S_REL_WR;
         end
         S_REL_WR: begin
            ram_we    = 1'b1;
            ram_addr  = cur_p_ff[OW-1:2];
            ram_wdata = ram_rdata & ~HDR_W'(1);
            state_in  = S_RESP;
         end
         // Hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         term_ff       <= term_of(RESET_LEN);
         base_ff       <= '0;
         free_off_ff   <= '0;
         free_valid_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         term_ff       <= term_in;
         base_ff       <= base_in;
         free_off_ff   <= free_off_in;
         free_valid_ff <= free_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      cmp_ff      <= cmp_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      cur_p_ff    <= cur_p_in;
      fsz_ff      <= fsz_in;
      wp_ff       <= wp_in;
      best_ff     <= best_in;
      bsize_ff    <= bsize_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/bthal_checker.sv
// Port-level checks for the heap allocator, bound to the top level.
`timescale 1ns / 1ps

module bthal_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input bthal_pkg::req_payload_type req_data,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input bthal_pkg::rsp_payload_type rsp_data,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input bthal_pkg::csr_index_type   csr_index,
   input logic [31:0]                csr_wdata
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A failure carries no block
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.block_addr == '0 && rsp_data.block_bytes == '0)
      else $error("failed response carries a block");

   // A granted block holds at least a header and one word
   a_grant_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.block_bytes != '0 |-> rsp_data.block_bytes >= 15'd8)
      else $error("granted block too small");

   // One transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !csr_ready)
      else $error("ready while a transaction is in flight");

endmodule

bind boundary_tag_heap_allocator bthal_checker u_bthal_checker (.*);
